[src/sorted_priority_queue_macros.svh]
// assertion helpers for the sorted priority queue
`ifndef SORTED_PRIORITY_QUEUE_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_MACROS_SVH

`ifndef SYNTHESIS
// property that holds in the same cycle
`define SPQ_ASSERT_NOW(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);
// property that holds in the cycle after a trigger
`define SPQ_ASSERT_NEXT(lbl, trig, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (expr)) else $error(msg);
`else
`define SPQ_ASSERT_NOW(lbl, expr, msg)
`define SPQ_ASSERT_NEXT(lbl, trig, expr, msg)
`endif

`endif

[src/spq_pkg.sv]
`default_nettype none

package spq_pkg;

  localparam int DATA_W = 32;

  // request codes
  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_REMOVE = 1'b1;

  // status codes
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

  // operation broadcast to every cell
  typedef struct packed {
    logic                     insert;
    logic                     remove;
    logic signed [DATA_W-1:0] value;
  } cmd_t;

  // state a cell shows its neighbors
  typedef struct packed {
    logic                     valid;
    logic signed [DATA_W-1:0] value;
    logic                     keep;
  } cell_t;

endpackage

`default_nettype wire

[src/spq_cell.sv]
`default_nettype none

module spq_cell (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire spq_pkg::cmd_t  cmd,
  input  wire spq_pkg::cell_t left,
  input  wire spq_pkg::cell_t right,
  output spq_pkg::cell_t      state
);

  logic                             valid;
  logic signed [spq_pkg::DATA_W-1:0] value;
  logic                             keep;
  logic                             valid_next;
  logic signed [spq_pkg::DATA_W-1:0] value_next;

  // stored entry stays put when it is smaller than the new value
  assign keep = valid && (value < cmd.value);

  // next entry: hold, take the new value, shift up from left or down from right
  always_comb begin
    valid_next = valid;
    value_next = value;
    if (cmd.insert) begin
      if (!keep) begin
        if (left.keep) begin
          valid_next = 1'b1;
          value_next = cmd.value;
        end else begin
          valid_next = left.valid;
          value_next = left.value;
        end
      end
    end else if (cmd.remove) begin
      valid_next = right.valid;
      value_next = right.value;
    end
  end

  // occupancy flag
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  // entry payload
  always_ff @(posedge clk) begin
    value <= value_next;
  end

  assign state = '{valid: valid, value: value, keep: keep};

endmodule

`default_nettype wire

[src/sorted_priority_queue.sv]
// sorted min-priority queue built as a row of compare-and-shift cells
// result: registered, shown in the cycle after its request is accepted
// throughput: one request per cycle while out_ready stays high; every cell
//   compares against the request in parallel, so no step waits on the row
// reset: clears the entry count, out_valid and every cell's occupancy flag;
//   entry payloads are left undefined until written
`default_nettype none

module sorted_priority_queue #(
  parameter int CAPACITY = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        req_type,
  input  wire logic signed [31:0] value,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic signed [31:0] removed_value,
  output logic signed [31:0] min_value,
  output logic             min_valid,
  output logic [4:0]       count,
  output logic [1:0]       status
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  spq_pkg::cmd_t  cmd;
  spq_pkg::cell_t cells [CAPACITY];
  spq_pkg::cell_t edge_left;
  spq_pkg::cell_t edge_right;

  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] cnt_next;
  logic             accept;
  logic             full;
  logic             empty;
  logic             rm_empty;
  logic [1:0]       status_next;
  logic signed [31:0] removed_next;

  // a new word enters once the previous result is gone or leaving
  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;
  assign full     = (cnt == CNT_W'(CAPACITY));
  assign empty    = (cnt == '0);
  assign rm_empty = accept && (req_type == spq_pkg::REQ_REMOVE) && empty;

  // request decode, dropped requests reach no cell
  always_comb begin
    cmd.insert   = accept && (req_type == spq_pkg::REQ_INSERT) && !full;
    cmd.remove   = accept && (req_type == spq_pkg::REQ_REMOVE) && !empty;
    cmd.value    = value;
    cnt_next     = cnt;
    status_next  = spq_pkg::STATUS_OK;
    removed_next = '0;
    if (req_type == spq_pkg::REQ_INSERT) begin
      if (full) begin
        status_next = spq_pkg::STATUS_FULL;
      end else begin
        cnt_next = cnt + 1'b1;
      end
    end else begin
      if (empty) begin
        status_next = spq_pkg::STATUS_EMPTY;
      end else begin
        cnt_next     = cnt - 1'b1;
        removed_next = cells[0].value;
      end
    end
  end

  // boundaries of the row
  assign edge_left  = '{valid: 1'b0, value: '0, keep: 1'b1};
  assign edge_right = '{valid: 1'b0, value: '0, keep: 1'b0};

  // row of cells, index 0 holds the minimum
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    spq_pkg::cell_t left_in;
    spq_pkg::cell_t right_in;
    if (i == 0) begin : g_first
      assign left_in = edge_left;
    end else begin : g_inner_l
      assign left_in = cells[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_in = edge_right;
    end else begin : g_inner_r
      assign right_in = cells[i+1];
    end
    spq_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .cmd   (cmd),
      .left  (left_in),
      .right (right_in),
      .state (cells[i])
    );
  end

  // entry count and result word
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        cnt       <= cnt_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      removed_value <= removed_next;
      status        <= status_next;
    end
  end

  // state is frozen while a result waits, so the minimum reads live
  assign min_valid = cells[0].valid;
  assign min_value = cells[0].valid ? cells[0].value : '0;
  assign count     = 5'(cnt);

`include "sorted_priority_queue_macros.svh"

  `SPQ_ASSERT_NOW(a_head_matches_count, cells[0].valid == (cnt != '0), "head flag vs count")
  `SPQ_ASSERT_NOW(a_tail_matches_full, cells[CAPACITY-1].valid == full, "tail flag vs full")
  `SPQ_ASSERT_NOW(a_stall_blocks_input, !(out_valid && !out_ready && in_ready), "stalled input")
  `SPQ_ASSERT_NEXT(a_empty_flag, rm_empty, status == spq_pkg::STATUS_EMPTY, "empty not flagged")
  `SPQ_ASSERT_NEXT(a_insert_grows, cmd.insert, cnt == $past(cnt) + 1'b1, "insert did not grow")

endmodule

`default_nettype wire
